// ----- hdl/hue_range_color_splash_top_defines.svh -----
// Assertion macros used by the hue range color splash checker.
`ifndef HUE_RANGE_COLOR_SPLASH_TOP_DEFINES_SVH
`define HUE_RANGE_COLOR_SPLASH_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HRCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HRCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/hrcs_pkg.sv -----
// Shared types, constants and the division step function of the hue range color splash block.
package hrcs_pkg;

    localparam int CHAN_W     = 8;
    localparam int HUE_W      = 9;
    localparam int DIVIDEND_W = 14;
    localparam int QUOT_W     = 6;
    localparam int PROD_W     = 24;
    localparam int CFG_INDEX_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_HUE_LOW       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HUE_HIGH      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERT_SELECT = 2'd2;

    localparam logic [HUE_W-1:0] HUE_LOW_RESET  = 9'd180;
    localparam logic [HUE_W-1:0] HUE_HIGH_RESET = 9'd230;

    // Sector base angles in degrees.
    localparam logic [HUE_W-1:0] HUE_BASE_RED   = 9'd0;
    localparam logic [HUE_W-1:0] HUE_BASE_GREEN = 9'd120;
    localparam logic [HUE_W-1:0] HUE_BASE_BLUE  = 9'd240;
    localparam logic [HUE_W-1:0] HUE_FULL       = 9'd360;

    // Luma weights 0.299 / 0.587 / 0.114 in Q16; they sum to 65536.
    localparam logic [PROD_W-1:0] LUMA_WR = 24'd19595;
    localparam logic [PROD_W-1:0] LUMA_WG = 24'd38470;
    localparam logic [PROD_W-1:0] LUMA_WB = 24'd7471;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue_low;
        logic [HUE_W-1:0] hue_high;
        logic             invert_select;
    } cfg_t;

    // Word leaving the sector decode stage.
    typedef struct packed {
        pixel_t              pix;
        logic                grey;
        logic                sub;
        logic [HUE_W-1:0]    base;
        logic [DIVIDEND_W-1:0] rem;
        logic [CHAN_W-1:0]   divisor;
        logic [QUOT_W-1:0]   quot;
        logic [PROD_W-1:0]   prod_r;
        logic [PROD_W-1:0]   prod_g;
        logic [PROD_W-1:0]   prod_b;
    } front_t;

    // Word moving through the divider stages.
    typedef struct packed {
        pixel_t              pix;
        logic                grey;
        logic                sub;
        logic [HUE_W-1:0]    base;
        logic [DIVIDEND_W-1:0] rem;
        logic [CHAN_W-1:0]   divisor;
        logic [QUOT_W-1:0]   quot;
        logic [CHAN_W-1:0]   luma;
    } work_t;

    // One restoring division step for quotient bit k.
    function automatic work_t div_bit(work_t w, logic [2:0] k);
        logic [DIVIDEND_W-1:0] trial;
        trial = DIVIDEND_W'(w.divisor) << k;
        if (w.rem >= trial)
        begin
            w.rem     = w.rem - trial;
            w.quot[k] = 1'b1;
        end
        return w;
    endfunction

endpackage

// ----- hdl/hrcs_front.sv -----
// Sector decode stage: finds the hue sector, the divide operands and the luma products.
module hrcs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  hrcs_pkg::pixel_t  in_pixel,
    output logic              out_valid,
    input  logic              out_ready,
    output hrcs_pkg::front_t  out_data
);

    logic             valid_reg;
    hrcs_pkg::front_t data_reg;
    hrcs_pkg::front_t data_next;

    logic [hrcs_pkg::CHAN_W-1:0] r, g, b, x, d;

    assign r = in_pixel.red;
    assign g = in_pixel.green;
    assign b = in_pixel.blue;

    // Each sector gives hue = base + q or base - ceil, with q = floor(60 * x / d).
    always_comb
    begin
        data_next      = '0;
        data_next.pix  = in_pixel;
        if (r >= g && g >= b)
        begin
            data_next.base = hrcs_pkg::HUE_BASE_RED;
            data_next.sub  = 1'b0;
            x = g - b;
            d = r - b;
        end
        else if (g > r && r >= b)
        begin
            data_next.base = hrcs_pkg::HUE_BASE_GREEN;
            data_next.sub  = 1'b1;
            x = r - b;
            d = g - b;
        end
        else if (g >= b && b > r)
        begin
            data_next.base = hrcs_pkg::HUE_BASE_GREEN;
            data_next.sub  = 1'b0;
            x = b - r;
            d = g - r;
        end
        else if (b > g && g > r)
        begin
            data_next.base = hrcs_pkg::HUE_BASE_BLUE;
            data_next.sub  = 1'b1;
            x = g - r;
            d = b - r;
        end
        else if (b > r && r >= g)
        begin
            data_next.base = hrcs_pkg::HUE_BASE_BLUE;
            data_next.sub  = 1'b0;
            x = r - g;
            d = b - g;
        end
        else
        begin
            data_next.base = hrcs_pkg::HUE_FULL;
            data_next.sub  = 1'b1;
            x = b - g;
            d = r - g;
        end
        data_next.grey    = (d == '0);
        data_next.divisor = d;
        data_next.rem     = (hrcs_pkg::DIVIDEND_W'(x) << 6) - (hrcs_pkg::DIVIDEND_W'(x) << 2);
        data_next.prod_r  = hrcs_pkg::PROD_W'(r) * hrcs_pkg::LUMA_WR;
        data_next.prod_g  = hrcs_pkg::PROD_W'(g) * hrcs_pkg::LUMA_WG;
        data_next.prod_b  = hrcs_pkg::PROD_W'(b) * hrcs_pkg::LUMA_WB;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- hdl/hrcs_div.sv -----
// Three-stage restoring divider, two quotient bits per stage, with the luma sum on the side.
module hrcs_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  hrcs_pkg::front_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output hrcs_pkg::work_t   out_data
);

    logic                     s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic                     s2_ready, s3_ready, s4_ready;
    hrcs_pkg::work_t          s2_reg, s3_reg, s4_reg;
    hrcs_pkg::work_t          s2_next, s3_next, s4_next;
    hrcs_pkg::work_t          entry;
    logic [hrcs_pkg::PROD_W-1:0] luma_sum;

    // The weighted sum never reaches 2^24, so the luma is bits 23:16.
    assign luma_sum = in_data.prod_r + in_data.prod_g + in_data.prod_b;

    always_comb
    begin
        entry.pix     = in_data.pix;
        entry.grey    = in_data.grey;
        entry.sub     = in_data.sub;
        entry.base    = in_data.base;
        entry.rem     = in_data.rem;
        entry.divisor = in_data.divisor;
        entry.quot    = in_data.quot;
        entry.luma    = luma_sum[hrcs_pkg::PROD_W-1:16];
        s2_next = hrcs_pkg::div_bit(hrcs_pkg::div_bit(entry, 3'd5), 3'd4);
        s3_next = hrcs_pkg::div_bit(hrcs_pkg::div_bit(s2_reg, 3'd3), 3'd2);
        s4_next = hrcs_pkg::div_bit(hrcs_pkg::div_bit(s3_reg, 3'd1), 3'd0);
    end

    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign in_ready = s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_ready)
            begin
                s2_valid_reg <= in_valid;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && in_valid)
        begin
            s2_reg <= s2_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_reg <= s3_next;
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_reg <= s4_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_data  = s4_reg;

endmodule

// ----- hdl/hrcs_back.sv -----
// Output stage: assembles the hue, tests it against the range and picks luma or pass-through.
module hrcs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  hrcs_pkg::cfg_t    cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  hrcs_pkg::work_t   in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output hrcs_pkg::pixel_t  out_pixel
);

    logic                       valid_reg;
    hrcs_pkg::pixel_t           pixel_reg;
    hrcs_pkg::pixel_t           pixel_next;
    logic [hrcs_pkg::HUE_W-1:0] hue_raw;
    logic [hrcs_pkg::HUE_W-1:0] hue;
    logic                       sel;

    always_comb
    begin
        // Falling sectors round down by taking the ceiling of the quotient off the base.
        if (in_data.sub)
        begin
            hue_raw = in_data.base - hrcs_pkg::HUE_W'(in_data.quot)
                      - hrcs_pkg::HUE_W'(in_data.rem != '0);
        end
        else
        begin
            hue_raw = in_data.base + hrcs_pkg::HUE_W'(in_data.quot);
        end
        // Grey has no hue and is taken as 0; a full turn wraps to 0.
        if (in_data.grey || hue_raw == hrcs_pkg::HUE_FULL)
        begin
            hue = '0;
        end
        else
        begin
            hue = hue_raw;
        end
        sel = (hue >= cfg.hue_low) && (hue <= cfg.hue_high);
        sel = sel ^ cfg.invert_select;
        if (sel)
        begin
            pixel_next.red   = in_data.luma;
            pixel_next.green = in_data.luma;
            pixel_next.blue  = in_data.luma;
        end
        else
        begin
            pixel_next = in_data.pix;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pixel = pixel_reg;

endmodule

// ----- hdl/hue_range_color_splash_top.sv -----
// Top level of the hue range color splash block with its configuration registers.
// Usage:
// One RGB pixel enters per word on the slave stream (s_tvalid, s_tready, s_tdata)
// and one pixel leaves per word on the master stream (m_tvalid, m_tready, m_tdata).
// A pixel whose hue in whole degrees lies inside [hue_low, hue_high] is replaced
// on all three channels by its luma; invert_select flips that choice. Other pixels
// pass unchanged.
// The pipeline has five register stages: sector decode, three divider stages that
// each resolve two quotient bits of the hue fraction, and the output register.
// A word passes the sector decode, divider and output registers in turn; the block takes
// one word per cycle while no stage stalls, set by the fully pipelined divider.
// Each stage holds its word while the next one is full, so when the receiver
// drops m_tready the pipeline fills up and s_tready falls only once every stage
// holds a word; nothing is lost or repeated.
// Configuration words on cfg_valid/cfg_index/cfg_data are always taken and
// should be written while no pixel is in flight. Index 0 is hue_low, 1 is
// hue_high, 2 is invert_select; index 3 is ignored.
// Reset (rst_n low, asynchronous) empties the pipeline and restores
// hue_low = 180, hue_high = 230 and invert_select = 0.
module hue_range_color_splash_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,   // in_red, in_green, in_blue
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata,   // out_red, out_green, out_blue
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hrcs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hrcs_pkg::HUE_W-1:0]          cfg_data
);

    hrcs_pkg::cfg_t   cfg_reg;
    hrcs_pkg::pixel_t in_pixel;
    hrcs_pkg::pixel_t out_pixel;
    hrcs_pkg::front_t front_data;
    hrcs_pkg::work_t  div_data;
    logic             front_valid, front_ready;
    logic             div_valid, div_ready;

    // Configuration writes are accepted in every cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hue_low       <= hrcs_pkg::HUE_LOW_RESET;
            cfg_reg.hue_high      <= hrcs_pkg::HUE_HIGH_RESET;
            cfg_reg.invert_select <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                hrcs_pkg::CFG_HUE_LOW:       cfg_reg.hue_low       <= cfg_data;
                hrcs_pkg::CFG_HUE_HIGH:      cfg_reg.hue_high      <= cfg_data;
                hrcs_pkg::CFG_INVERT_SELECT: cfg_reg.invert_select <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Red sits in the lowest byte of the word.
    assign in_pixel.red   = s_tdata[7:0];
    assign in_pixel.green = s_tdata[15:8];
    assign in_pixel.blue  = s_tdata[23:16];

    hrcs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pixel  (in_pixel),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    hrcs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    hrcs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_data   (div_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pixel (out_pixel)
    );

    assign m_tdata = {out_pixel.blue, out_pixel.green, out_pixel.red};

endmodule

// ----- hdl/hrcs_checker.sv -----
// Port-level assertions of the hue range color splash block, bound to its top level.
`include "hue_range_color_splash_top_defines.svh"

module hrcs_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [23:0]                         m_tdata,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready
);

    // A stalled output word stays and keeps its value.
    `HRCS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")

    // With the receiver ready every stage drains, so the input side must be open.
    `HRCS_ASSERT_NOW(a_ready_chain, clk, rst_n, m_tready, s_tready, "input stalled although the output is ready")

    // Leaving reset the pipeline is empty.
    `HRCS_ASSERT_NOW(a_reset_empty, clk, rst_n, $rose(rst_n), !m_tvalid, "output word present right after reset")

    // Configuration words are never refused.
    `HRCS_ASSERT_NOW(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready, "configuration word refused")

endmodule

bind hue_range_color_splash_top hrcs_checker u_checker (.*);

// ----- tb/hue_range_color_splash_top_test.sv -----
// Self-checking testbench for the hue range color splash block, with its own pixel predictor.
module hue_range_color_splash_top_test;

    // A stream word: red in the lowest byte, then green, then blue.
    typedef struct packed {
        logic [hrcs_pkg::CHAN_W-1:0] blue;
        logic [hrcs_pkg::CHAN_W-1:0] green;
        logic [hrcs_pkg::CHAN_W-1:0] red;
    } rgb_word_t;

    // How the receiver drives m_tready during a phase.
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PATTERN,
        READY_LONG_STALL
    } ready_mode_e;

    // The configuration port has no register behind this index.
    localparam logic [hrcs_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    // Luma weights in Q16; they add up to exactly 65536, so luma never exceeds 255.
    localparam int unsigned LUMA_R_Q16 = 19595;
    localparam int unsigned LUMA_G_Q16 = 38470;
    localparam int unsigned LUMA_B_Q16 = 7471;

    // The pipeline is five stages deep; this margin covers it with room to spare.
    localparam int SETTLE_CYCLES = 12;
    // Covers roughly two thousand words, receiver stalls included, several times over.
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 100;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [23:0]                      s_tdata = '0;       // in_red, in_green, in_blue
    logic                             m_tvalid;
    logic                             m_tready = 1'b1;
    logic [23:0]                      m_tdata;            // out_red, out_green, out_blue
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [hrcs_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [hrcs_pkg::HUE_W-1:0]       cfg_data = '0;

    // The predictor's copy of the registers, starting at their reset values.
    logic [hrcs_pkg::HUE_W-1:0]       key_low = 9'd180;
    logic [hrcs_pkg::HUE_W-1:0]       key_high = 9'd230;
    logic                             key_invert = 1'b0;

    // Pixels the block is expected to emit, oldest first.
    rgb_word_t              expected_pixels[$];

    int                     mismatches = 0;
    int                     words_checked = 0;
    int unsigned            cycles_run = 0;

    // Sender burst control: gap_limit of zero means the sender never idles.
    int                     gap_limit = 0;
    int                     burst_left = 0;

    // Receiver stall control.
    ready_mode_e            ready_mode = READY_ALWAYS;
    int                     stall_left = 0;
    int                     pattern_step = 0;

    hue_range_color_splash_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Hue in whole degrees from the six-sector max/min rule, rounded down.
    // Each sector is written so that the numerator stays non-negative.
    // A grey pixel has no hue and is given 0.
    function automatic int unsigned hue_degrees(input int unsigned r, input int unsigned g,
                                                input int unsigned b);
        int unsigned num;
        int unsigned den;
        if (r >= g && g >= b)
        begin
            if (r == b)
                return 0;
            num = 60 * (g - b);
            den = r - b;
        end
        else if (g > r && r >= b)
        begin
            num = 120 * (g - b) - 60 * (r - b);
            den = g - b;
        end
        else if (g >= b && b > r)
        begin
            num = 120 * (g - r) + 60 * (b - r);
            den = g - r;
        end
        else if (b > g && g > r)
        begin
            num = 240 * (b - r) - 60 * (g - r);
            den = b - r;
        end
        else if (b > r && r >= g)
        begin
            num = 240 * (b - g) + 60 * (r - g);
            den = b - g;
        end
        else if (r >= b && b > g)
        begin
            num = 360 * (r - g) - 60 * (b - g);
            den = r - g;
        end
        else
            return 0;
        if (den == 0)
            return 0;
        return (num / den) % 360;
    endfunction

    // The pixel the block should emit for px under the current register values.
    // Bounds are compared as plain 9-bit numbers, so a bound above 359 simply
    // never lies below a hue, and a low bound above the high one matches nothing.
    function automatic rgb_word_t splash_pixel(input rgb_word_t px);
        int unsigned hue;
        int unsigned luma;
        logic        chosen;
        hue = hue_degrees(px.red, px.green, px.blue);
        chosen = (hue >= key_low) && (hue <= key_high);
        if (key_invert)
            chosen = !chosen;
        if (chosen)
        begin
            luma = (LUMA_R_Q16 * px.red + LUMA_G_Q16 * px.green + LUMA_B_Q16 * px.blue) >> 16;
            px.red = luma[hrcs_pkg::CHAN_W-1:0];
            px.green = luma[hrcs_pkg::CHAN_W-1:0];
            px.blue = luma[hrcs_pkg::CHAN_W-1:0];
        end
        return px;
    endfunction

    function automatic rgb_word_t make_rgb(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        rgb_word_t px;
        px.red = r;
        px.green = g;
        px.blue = b;
        return px;
    endfunction

    // Mostly uniform pixels, with a share of greys, ties between two channels
    // (the sector borders) and channels pinned near 0 or 255.
    function automatic rgb_word_t random_pixel();
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        int         kind;
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        kind = $urandom_range(0, 9);
        case (kind)
            0:
            begin
                g = r;
                b = r;
            end
            1: g = r;
            2: b = g;
            3: b = r;
            4:
            begin
                r = $urandom_range(0, 1) ? 8'($urandom_range(254, 255)) : 8'($urandom_range(0, 1));
                g = $urandom_range(0, 1) ? 8'($urandom_range(254, 255)) : 8'($urandom_range(0, 1));
                b = $urandom_range(0, 1) ? 8'($urandom_range(254, 255)) : 8'($urandom_range(0, 1));
            end
            default: ;
        endcase
        return make_rgb(r, g, b);
    endfunction

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch at word %0d: %s", words_checked, what);
        mismatches++;
    endtask

    // Sends one pixel word. The sender works in bursts; at the start of each
    // burst it drops s_tvalid for a random gap. The expected pixel is queued
    // at the edge where the word is accepted, using the registers as they are.
    task automatic send_pixel(input rgb_word_t px);
        int gap;
        if (gap_limit != 0 && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(1, gap_limit);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (burst_left != 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= px;
        do
            @(posedge clk);
        while (!s_tready);
        expected_pixels.push_back(splash_pixel(px));
    endtask

    // Stops the stream and waits until every expected pixel has come back,
    // then lets settle further cycles pass.
    task automatic wait_for_idle(input int settle);
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_pixels.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    // Writes one register. cfg_valid stays high between back-to-back writes and
    // is dropped at the acceptance of the word marked last.
    task automatic write_register(input logic [hrcs_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [hrcs_pkg::HUE_W-1:0] value, input logic last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (last)
            cfg_valid <= 1'b0;
        case (idx)
            hrcs_pkg::CFG_HUE_LOW:       key_low = value;
            hrcs_pkg::CFG_HUE_HIGH:      key_high = value;
            hrcs_pkg::CFG_INVERT_SELECT: key_invert = value[0];
            default: ;
        endcase
    endtask

    // Primary colors, the sector borders, greys and pixels just inside and just
    // outside the reset range of 180 to 230 degrees, all with reset registers.
    task automatic test_reset_values();
        gap_limit = 0;
        ready_mode = READY_RANDOM;
        send_pixel(make_rgb(8'd0, 8'd0, 8'd0));
        send_pixel(make_rgb(8'd255, 8'd255, 8'd255));
        send_pixel(make_rgb(8'd128, 8'd128, 8'd128));
        send_pixel(make_rgb(8'd255, 8'd0, 8'd0));
        send_pixel(make_rgb(8'd255, 8'd255, 8'd0));
        send_pixel(make_rgb(8'd0, 8'd255, 8'd0));
        send_pixel(make_rgb(8'd0, 8'd255, 8'd255));
        send_pixel(make_rgb(8'd0, 8'd0, 8'd255));
        send_pixel(make_rgb(8'd255, 8'd0, 8'd255));
        send_pixel(make_rgb(8'd0, 8'd255, 8'd254));
        send_pixel(make_rgb(8'd0, 8'd42, 8'd255));
        send_pixel(make_rgb(8'd0, 8'd38, 8'd255));
        send_pixel(make_rgb(8'd255, 8'd0, 8'd1));
        send_pixel(make_rgb(8'd255, 8'd1, 8'd0));
        send_pixel(make_rgb(8'd1, 8'd0, 8'd0));
        send_pixel(make_rgb(8'd255, 8'd254, 8'd0));
        send_pixel(make_rgb(8'd0, 8'd1, 8'd1));
        send_pixel(make_rgb(8'd254, 8'd255, 8'd255));
        send_pixel(make_rgb(8'd1, 8'd2, 8'd3));
    endtask

    // Settings at the edges of the registers: the full 9-bit range, an empty
    // range, bounds above 359 and single-degree ranges, with invert set on some of them.
    // One setting also writes the unused index, which must change nothing.
    task automatic test_range_extremes();
        logic [hrcs_pkg::HUE_W-1:0] lows[7] = '{9'd0, 9'd0, 9'd360, 9'd511, 9'd0, 9'd359,
                                                 9'd100};
        logic [hrcs_pkg::HUE_W-1:0] highs[7] = '{9'd511, 9'd511, 9'd0, 9'd511, 9'd0, 9'd359,
                                                  9'd50};
        logic [hrcs_pkg::HUE_W-1:0] inverts[7] = '{9'd0, 9'd511, 9'd0, 9'd1, 9'd0, 9'd256,
                                                    9'd1};
        ready_mode = READY_PATTERN;
        gap_limit = 3;
        for (int i = 0; i < 7; i++)
        begin
            wait_for_idle(SETTLE_CYCLES);
            if (i == 3)
                write_register(CFG_UNUSED_INDEX, 9'($urandom_range(0, 511)), 1'b0);
            write_register(hrcs_pkg::CFG_HUE_LOW, lows[i], 1'b0);
            write_register(hrcs_pkg::CFG_HUE_HIGH, highs[i], 1'b0);
            write_register(hrcs_pkg::CFG_INVERT_SELECT, inverts[i], 1'b1);
            for (int n = 0; n < 30; n++)
                send_pixel(random_pixel());
        end
    endtask

    // Random register settings, each followed by a long run of random pixels
    // under its own sender and receiver idling. The first phase runs without
    // any idling, and in one phase the sender stops until the block is empty.
    task automatic test_random_settings();
        logic [hrcs_pkg::HUE_W-1:0] low;
        logic [hrcs_pkg::HUE_W-1:0] high;
        for (int phase = 0; phase < 7; phase++)
        begin
            wait_for_idle(SETTLE_CYCLES);
            case ($urandom_range(0, 3))
                0:
                begin
                    low = 9'($urandom_range(0, 359));
                    high = low + 9'($urandom_range(0, 90));
                end
                1:
                begin
                    low = 9'($urandom_range(0, 511));
                    high = 9'($urandom_range(0, 511));
                end
                2:
                begin
                    low = 9'd0;
                    high = 9'($urandom_range(0, 359));
                end
                default:
                begin
                    low = 9'($urandom_range(0, 359));
                    high = 9'($urandom_range(360, 511));
                end
            endcase
            write_register(hrcs_pkg::CFG_HUE_LOW, low, 1'b0);
            write_register(hrcs_pkg::CFG_HUE_HIGH, high, 1'b0);
            write_register(hrcs_pkg::CFG_INVERT_SELECT, 9'($urandom_range(0, 511)), 1'b1);
            if (phase == 0)
            begin
                gap_limit = 0;
                ready_mode = READY_ALWAYS;
            end
            else
            begin
                gap_limit = $urandom_range(0, 6);
                ready_mode = ready_mode_e'($urandom_range(0, 3));
            end
            for (int n = 0; n < 240; n++)
            begin
                if (phase == 3 && n == 120)
                    wait_for_idle(0);
                send_pixel(random_pixel());
            end
        end
    endtask

    // The receiver drives m_tready on a pattern of its own, chosen per phase.
    always @(posedge clk)
    begin : receiver
        pattern_step++;
        case (ready_mode)
            READY_ALWAYS:
                m_tready <= 1'b1;
            READY_RANDOM:
                m_tready <= ($urandom_range(0, 3) != 0);
            READY_PATTERN:
                m_tready <= ((pattern_step % 7) >= 3);
            default:
            begin
                if (stall_left != 0)
                begin
                    stall_left--;
                    m_tready <= 1'b0;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    stall_left = $urandom_range(4, 24);
                    m_tready <= 1'b0;
                end
                else
                    m_tready <= 1'b1;
            end
        endcase
    end

    // Every accepted output word is compared field by field with the oldest
    // expected pixel. Values are read at the edge, before the block updates.
    always @(posedge clk)
    begin : result_check
        rgb_word_t got;
        rgb_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_pixels.size() == 0)
                report_mismatch($sformatf("word %06h arrived with nothing expected", got));
            else
            begin
                want = expected_pixels.pop_front();
                if (got.red != want.red)
                    report_mismatch($sformatf("out_red %0d, expected %0d", got.red, want.red));
                if (got.green != want.green)
                    report_mismatch($sformatf("out_green %0d, expected %0d",
                                              got.green, want.green));
                if (got.blue != want.blue)
                    report_mismatch($sformatf("out_blue %0d, expected %0d",
                                              got.blue, want.blue));
            end
            words_checked++;
        end
    end

    // Watchdog: a run that is still going after the limit has hung.
    initial
    begin
        while (cycles_run < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("FAILURE");
        $finish;
    end

    // Reset once, run the tests in turn, drain the pipeline and give the verdict.
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_range_extremes();
        test_random_settings();
        wait_for_idle(SETTLE_CYCLES);
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
